### rtl/rlcs_pkg.sv
// ----------------------------------------------------------------------------
// rlcs_pkg
// Shared types and constants of the serial RGB LED chain driver.
// ----------------------------------------------------------------------------
package rlcs_pkg;

    // Item operation codes.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Field and word widths.
    localparam int COLOR_W      = 24;
    localparam int CHAN_W       = 8;
    localparam int IDX_W        = 3;
    localparam int BIT_CNT_W    = 5;
    localparam int TICK_W       = 8;
    localparam int GAP_W        = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(COLOR_W - 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_ONE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_ZERO = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_TICKS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LATCH     = 3'd3;

    // Configuration reset values.
    localparam logic [TICK_W-1:0] RST_HIGH_ONE  = 8'd16;
    localparam logic [TICK_W-1:0] RST_HIGH_ZERO = 8'd8;
    localparam logic [TICK_W-1:0] RST_BIT_TICKS = 8'd25;
    localparam logic [GAP_W-1:0]  RST_LATCH     = 16'd1000;
    localparam logic [TICK_W-1:0] MIN_PERIOD    = 8'd2;

    // Effective timing after clamping.
    typedef struct packed {
        logic [TICK_W-1:0] high_one;
        logic [TICK_W-1:0] high_zero;
        logic [TICK_W-1:0] period;
        logic [GAP_W-1:0]  latch;
    } t_timing;

    // One result item.
    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic frame_done;
        logic bad_index;
    } t_result;

endpackage

### rtl/rlcs_cfg.sv
// ----------------------------------------------------------------------------
// rlcs_cfg
// Timing configuration registers with period and high time clamping.
// ----------------------------------------------------------------------------
module rlcs_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_wr_en,
    input  logic [rlcs_pkg::CFG_IDX_W-1:0]     i_wr_index,
    input  logic [rlcs_pkg::CFG_DATA_W-1:0]    i_wr_data,
    output rlcs_pkg::t_timing                  o_timing
);

    logic [rlcs_pkg::TICK_W-1:0] r_high_one;
    logic [rlcs_pkg::TICK_W-1:0] r_high_zero;
    logic [rlcs_pkg::TICK_W-1:0] r_bit_ticks;
    logic [rlcs_pkg::GAP_W-1:0]  r_latch;
    logic [rlcs_pkg::TICK_W-1:0] w_period;
    logic [rlcs_pkg::TICK_W-1:0] w_limit;

    // Register writes; indexes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_one  <= rlcs_pkg::RST_HIGH_ONE;
            r_high_zero <= rlcs_pkg::RST_HIGH_ZERO;
            r_bit_ticks <= rlcs_pkg::RST_BIT_TICKS;
            r_latch     <= rlcs_pkg::RST_LATCH;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                rlcs_pkg::CFG_HIGH_ONE:  r_high_one  <= i_wr_data[rlcs_pkg::TICK_W-1:0];
                rlcs_pkg::CFG_HIGH_ZERO: r_high_zero <= i_wr_data[rlcs_pkg::TICK_W-1:0];
                rlcs_pkg::CFG_BIT_TICKS: r_bit_ticks <= i_wr_data[rlcs_pkg::TICK_W-1:0];
                rlcs_pkg::CFG_LATCH:     r_latch     <= i_wr_data;
                default: ;
            endcase
        end
    end

    // A bit period is at least two ticks, and a high time leaves at least one low tick.
    assign w_period = (r_bit_ticks < rlcs_pkg::MIN_PERIOD) ? rlcs_pkg::MIN_PERIOD : r_bit_ticks;
    assign w_limit  = w_period - rlcs_pkg::TICK_W'(1);

    assign o_timing.high_one  = (r_high_one > w_limit) ? w_limit : r_high_one;
    assign o_timing.high_zero = (r_high_zero > w_limit) ? w_limit : r_high_zero;
    assign o_timing.period    = w_period;
    assign o_timing.latch     = r_latch;

endmodule

### rtl/rlcs_engine.sv
// ----------------------------------------------------------------------------
// rlcs_engine
// Color store and frame state; one item is applied per step.
// ----------------------------------------------------------------------------
module rlcs_engine #(
    parameter int NUM_LEDS = 3
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_step,
    input  logic                             i_operation,
    input  logic [rlcs_pkg::IDX_W-1:0]       i_led_index,
    input  logic [rlcs_pkg::COLOR_W-1:0]     i_color,
    input  rlcs_pkg::t_timing                i_timing,
    output rlcs_pkg::t_result                o_result
);

    localparam int LED_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam logic [LED_W-1:0] LAST_LED = LED_W'(NUM_LEDS - 1);
    localparam logic [rlcs_pkg::IDX_W:0] LED_COUNT = (rlcs_pkg::IDX_W + 1)'(NUM_LEDS);

    logic [rlcs_pkg::COLOR_W-1:0]   r_store [NUM_LEDS];
    logic [rlcs_pkg::COLOR_W-1:0]   r_shift,  n_shift;
    logic [LED_W-1:0]               r_led,    n_led;
    logic [rlcs_pkg::BIT_CNT_W-1:0] r_bit,    n_bit;
    logic [rlcs_pkg::TICK_W-1:0]    r_phase,  n_phase;
    logic [rlcs_pkg::GAP_W-1:0]     r_gap,    n_gap;
    logic                           r_sending, n_sending;
    logic                           r_resend,  n_resend;

    logic                           w_wr_en;
    logic [LED_W-1:0]               w_wr_idx;
    logic                           w_frm_idle;
    logic                           w_start;
    logic [rlcs_pkg::COLOR_W-1:0]   w_cur_shift;
    logic [rlcs_pkg::TICK_W-1:0]    w_cur_phase;
    logic [rlcs_pkg::BIT_CNT_W-1:0] w_cur_bit;
    logic [LED_W-1:0]               w_cur_led;
    logic [LED_W-1:0]               w_next_led;
    logic [rlcs_pkg::TICK_W-1:0]    w_high;
    logic                           w_bit_end;

    assign w_wr_idx   = i_led_index[LED_W-1:0];
    assign w_frm_idle = !r_sending && (r_gap == '0);
    assign w_start    = w_frm_idle && r_resend;

    // A pending resend starts the frame on the tick itself.
    assign w_cur_shift = w_start ? r_store[0] : r_shift;
    assign w_cur_phase = w_start ? '0 : r_phase;
    assign w_cur_bit   = w_start ? '0 : r_bit;
    assign w_cur_led   = w_start ? '0 : r_led;
    assign w_next_led  = (w_cur_led == LAST_LED) ? '0 : w_cur_led + LED_W'(1);

    assign w_high    = w_cur_shift[rlcs_pkg::COLOR_W-1] ? i_timing.high_one : i_timing.high_zero;
    assign w_bit_end = ({1'b0, w_cur_phase} + 9'd1) >= {1'b0, i_timing.period};

    // Next state and result of the item being applied.
    always_comb begin
        n_shift   = r_shift;
        n_led     = r_led;
        n_bit     = r_bit;
        n_phase   = r_phase;
        n_gap     = r_gap;
        n_sending = r_sending;
        n_resend  = r_resend;
        w_wr_en   = 1'b0;
        o_result  = '0;
        if (i_operation == rlcs_pkg::OP_WRITE) begin
            if ({1'b0, i_led_index} >= LED_COUNT) begin
                o_result.bad_index = 1'b1;
                o_result.busy_res  = !w_frm_idle;
            end else begin
                w_wr_en           = i_step;
                o_result.busy_res = 1'b1;
                if (!w_frm_idle) begin
                    n_resend = 1'b1;
                end else begin
                    n_sending = 1'b1;
                    n_resend  = 1'b0;
                    n_led     = '0;
                    n_bit     = '0;
                    n_phase   = '0;
                    n_shift   = (w_wr_idx == '0) ? i_color : r_store[0];
                end
            end
        end else if (r_sending || w_start) begin
            n_sending           = 1'b1;
            n_resend            = w_start ? 1'b0 : r_resend;
            n_led               = w_cur_led;
            n_bit               = w_cur_bit;
            n_shift             = w_cur_shift;
            o_result.line_level = w_cur_phase < w_high;
            o_result.busy_res   = 1'b1;
            if (w_bit_end) begin
                n_phase = '0;
                n_shift = {w_cur_shift[rlcs_pkg::COLOR_W-2:0], 1'b0};
                n_bit   = w_cur_bit + rlcs_pkg::BIT_CNT_W'(1);
                if (w_cur_bit == rlcs_pkg::LAST_BIT) begin
                    n_bit = '0;
                    n_led = w_next_led;
                    if (w_cur_led == LAST_LED) begin
                        n_sending           = 1'b0;
                        n_gap               = i_timing.latch;
                        o_result.frame_done = 1'b1;
                    end else begin
                        n_shift = r_store[w_next_led];
                    end
                end
            end else begin
                n_phase = w_cur_phase + rlcs_pkg::TICK_W'(1);
            end
        end else if (r_gap != '0) begin
            n_gap             = r_gap - rlcs_pkg::GAP_W'(1);
            o_result.busy_res = 1'b1;
        end
    end

    // State update on each applied item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift   <= '0;
            r_led     <= '0;
            r_bit     <= '0;
            r_phase   <= '0;
            r_gap     <= '0;
            r_sending <= 1'b0;
            r_resend  <= 1'b0;
        end else if (i_step) begin
            r_shift   <= n_shift;
            r_led     <= n_led;
            r_bit     <= n_bit;
            r_phase   <= n_phase;
            r_gap     <= n_gap;
            r_sending <= n_sending;
            r_resend  <= n_resend;
        end
    end

    // Color store, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LEDS; i++) begin
                r_store[i] <= '0;
            end
        end else if (w_wr_en) begin
            r_store[w_wr_idx] <= i_color;
        end
    end

endmodule

### rtl/rgb_led_chain_serializer_core.sv
// ----------------------------------------------------------------------------
// rgb_led_chain_serializer_core
// Serial RGB LED chain driver: stores one color per LED and produces one
// data line level per tick item.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake               Content
//   in       input      i_in_valid/o_in_stall   operation, LED index, color
//   out      output     o_out_valid/i_out_stall line level, busy, done, bad index
//   cfg      input      i_cfg_valid/o_cfg_ready register index and data
//
// One item per clock cycle while the output is not stalled: a transfer
// lands in the input register and is applied to the frame state once the
// output register is free. The edge that updates the state also loads the
// result register, which offers the result until it is taken.
// Reset clears the configuration to its defaults, the color store to zero and
// the frame state to idle. A stalled output holds the pipeline; the input
// register is still filled while it is empty, and the input stalls only when
// both registers are full and the output is stalled.
// ----------------------------------------------------------------------------
module rgb_led_chain_serializer_core #(
    parameter int NUM_LEDS = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_operation,
    input  logic [rlcs_pkg::IDX_W-1:0]        i_led_index,
    input  logic [rlcs_pkg::CHAN_W-1:0]       i_red,
    input  logic [rlcs_pkg::CHAN_W-1:0]       i_green,
    input  logic [rlcs_pkg::CHAN_W-1:0]       i_blue,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_line_level,
    output logic                              o_busy_res,
    output logic                              o_frame_done,
    output logic                              o_bad_index,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rlcs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rlcs_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic                           r_in_valid;
    logic                           r_in_op;
    logic [rlcs_pkg::IDX_W-1:0]     r_in_idx;
    logic [rlcs_pkg::COLOR_W-1:0]   r_in_color;
    logic                           r_out_valid;
    rlcs_pkg::t_result              r_out;
    rlcs_pkg::t_result              w_result;
    rlcs_pkg::t_timing              w_timing;
    logic                           w_out_free;
    logic                           w_step;
    logic                           w_in_take;

    // Pipeline control.
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_step     = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;
    assign w_in_take  = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_op    <= i_operation;
            r_in_idx   <= i_led_index;
            r_in_color <= {i_green, i_red, i_blue};
        end
    end

    // Configuration registers.
    rlcs_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_timing   (w_timing)
    );

    // Frame engine.
    rlcs_engine #(
        .NUM_LEDS (NUM_LEDS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_operation (r_in_op),
        .i_led_index (r_in_idx),
        .i_color     (r_in_color),
        .i_timing    (w_timing),
        .o_result    (w_result)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_line_level = r_out.line_level;
    assign o_busy_res   = r_out.busy_res;
    assign o_frame_done = r_out.frame_done;
    assign o_bad_index  = r_out.bad_index;

endmodule

### rtl/rlcs_checker.sv
// ----------------------------------------------------------------------------
// rlcs_checker
// Port level checks of the LED chain driver, bound to the top level.
// ----------------------------------------------------------------------------
module rlcs_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              o_out_valid,
    input  logic                              i_out_stall,
    input  logic                              o_line_level,
    input  logic                              o_busy_res,
    input  logic                              o_frame_done,
    input  logic                              o_bad_index
);

    // A stalled result stays and holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid
            && $stable({o_line_level, o_busy_res, o_frame_done, o_bad_index}))
        else $error("stalled result changed");

    // The end of a frame is still reported as busy.
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_done |-> o_busy_res)
        else $error("frame end without busy");

    // The last tick of a bit is always low, so the frame end is low.
    a_done_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_done |-> !o_line_level)
        else $error("line high on frame end");

    // A rejected write drives no line level and ends no frame.
    a_bad_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bad_index |-> !o_line_level && !o_frame_done)
        else $error("bad index result carries line activity");

    // The line is only driven high during a frame.
    a_high_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_line_level |-> o_busy_res)
        else $error("line high while idle");

endmodule

bind rgb_led_chain_serializer_core rlcs_checker u_rlcs_checker (.*);

### dv/rgb_led_chain_serializer_core_test.sv
// ----------------------------------------------------------------------------
// rgb_led_chain_serializer_core_test
// Self-checking testbench of the serial RGB LED chain driver. A scoreboard
// class tracks the color store and the frame state, predicts the result of
// every accepted item and checks the results in order. The run walks through
// several timing settings, including the clamped and extreme ones, with random
// idle cycles and stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rgb_led_chain_serializer_core_test;

    localparam int LED_COUNT  = 3;
    localparam int CLK_PERIOD = 8;
    localparam int SETTLE_GAP = 4;
    localparam int CYCLE_CAP  = 300000;
    localparam int HOLD_LEN   = 400;
    localparam int HOLD_AT    = 700;

    // One input item as it is driven on the ports.
    typedef struct packed {
        logic                        operation;
        logic [rlcs_pkg::IDX_W-1:0]  led_index;
        logic [rlcs_pkg::CHAN_W-1:0] red;
        logic [rlcs_pkg::CHAN_W-1:0] green;
        logic [rlcs_pkg::CHAN_W-1:0] blue;
    } t_led_item;

    // Tracks the chain state and holds the line results still to come.
    class led_line_board;
        logic [rlcs_pkg::TICK_W-1:0]  high_one;
        logic [rlcs_pkg::TICK_W-1:0]  high_zero;
        logic [rlcs_pkg::TICK_W-1:0]  period_cfg;
        logic [rlcs_pkg::GAP_W-1:0]   latch_cfg;
        logic [rlcs_pkg::COLOR_W-1:0] colors [LED_COUNT];
        logic [rlcs_pkg::COLOR_W-1:0] shift_word;
        int unsigned led_cnt;
        int unsigned bit_cnt;
        int unsigned phase;
        int unsigned gap;
        bit sending;
        bit resend;
        rlcs_pkg::t_result expected_lines[$];
        int mismatches;

        function new();
            high_one   = rlcs_pkg::RST_HIGH_ONE;
            high_zero  = rlcs_pkg::RST_HIGH_ZERO;
            period_cfg = rlcs_pkg::RST_BIT_TICKS;
            latch_cfg  = rlcs_pkg::RST_LATCH;
            foreach (colors[i]) colors[i] = '0;
            shift_word = '0;
            led_cnt = 0;
            bit_cnt = 0;
            phase = 0;
            gap = 0;
            sending = 0;
            resend = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_lines.size();
        endfunction

        function void note_config(logic [rlcs_pkg::CFG_IDX_W-1:0] idx,
                                  logic [rlcs_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                rlcs_pkg::CFG_HIGH_ONE: begin
                    high_one = data[rlcs_pkg::TICK_W-1:0];
                end
                rlcs_pkg::CFG_HIGH_ZERO: begin
                    high_zero = data[rlcs_pkg::TICK_W-1:0];
                end
                rlcs_pkg::CFG_BIT_TICKS: begin
                    period_cfg = data[rlcs_pkg::TICK_W-1:0];
                end
                rlcs_pkg::CFG_LATCH: begin
                    latch_cfg = data;
                end
                default: begin
                end
            endcase
        endfunction

        function void begin_frame();
            sending = 1;
            resend = 0;
            led_cnt = 0;
            bit_cnt = 0;
            phase = 0;
            shift_word = colors[0];
        endfunction

        // Apply one accepted item to the frame state and queue its result.
        function void note_input(t_led_item it);
            rlcs_pkg::t_result res;
            int unsigned period;
            int unsigned high;
            res = '0;
            if (it.operation == rlcs_pkg::OP_WRITE) begin
                if (int'(it.led_index) >= LED_COUNT) begin
                    res.bad_index = 1'b1;
                end else begin
                    colors[it.led_index] = {it.green, it.red, it.blue};
                    if (sending || gap != 0) resend = 1;
                    else begin_frame();
                end
                res.busy_res = sending || gap != 0;
            end else begin
                if (!sending && gap == 0 && resend) begin_frame();
                if (sending) begin
                    period = (period_cfg < rlcs_pkg::MIN_PERIOD) ? rlcs_pkg::MIN_PERIOD
                                                                 : period_cfg;
                    high = shift_word[rlcs_pkg::COLOR_W-1] ? high_one : high_zero;
                    if (high > period - 1) high = period - 1;
                    res.line_level = phase < high;
                    res.busy_res = 1'b1;
                    if (phase + 1 >= period) begin
                        phase = 0;
                        shift_word = shift_word << 1;
                        bit_cnt++;
                        if (bit_cnt >= rlcs_pkg::COLOR_W) begin
                            bit_cnt = 0;
                            led_cnt++;
                            if (led_cnt >= LED_COUNT) begin
                                led_cnt = 0;
                                sending = 0;
                                gap = latch_cfg;
                                res.frame_done = 1'b1;
                            end else begin
                                shift_word = colors[led_cnt];
                            end
                        end
                    end else begin
                        phase++;
                    end
                end else if (gap != 0) begin
                    gap--;
                    res.busy_res = 1'b1;
                end
            end
            expected_lines.push_back(res);
        endfunction

        // Compare one accepted result with the oldest expected one.
        function void check_result(rlcs_pkg::t_result got);
            rlcs_pkg::t_result want;
            if (expected_lines.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %b arrived with nothing expected", got);
                return;
            end
            want = expected_lines.pop_front();
            if (got.line_level !== want.line_level || got.busy_res !== want.busy_res ||
                got.frame_done !== want.frame_done || got.bad_index !== want.bad_index) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR at %0t: level/busy/done/bad expected %b%b%b%b got %b%b%b%b",
                             $time, want.line_level, want.busy_res, want.frame_done,
                             want.bad_index, got.line_level, got.busy_res, got.frame_done,
                             got.bad_index);
            end
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_stall;
    logic                            i_operation;
    logic [rlcs_pkg::IDX_W-1:0]      i_led_index;
    logic [rlcs_pkg::CHAN_W-1:0]     i_red;
    logic [rlcs_pkg::CHAN_W-1:0]     i_green;
    logic [rlcs_pkg::CHAN_W-1:0]     i_blue;
    logic                            o_out_valid;
    logic                            i_out_stall;
    logic                            o_line_level;
    logic                            o_busy_res;
    logic                            o_frame_done;
    logic                            o_bad_index;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [rlcs_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [rlcs_pkg::CFG_DATA_W-1:0] i_cfg_data;

    led_line_board board = new();
    int unsigned items_sent = 0;
    int unsigned results_seen = 0;
    int unsigned send_idle_pct = 37;
    int unsigned recv_idle_pct = 70;
    int unsigned cycles = 0;

    rgb_led_chain_serializer_core #(
        .NUM_LEDS(LED_COUNT)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .i_led_index (i_led_index),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_line_level(o_line_level),
        .o_busy_res  (o_busy_res),
        .o_frame_done(o_frame_done),
        .o_bad_index (o_bad_index),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Cycle counter that ends a hung run.
    initial begin
        while (cycles < CYCLE_CAP) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Output side: random stalls, plus one long hold-off that backs up the block.
    initial begin
        int unsigned hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Check every result transfer against the oldest expectation.
    always @(posedge i_clk) begin : result_monitor
        rlcs_pkg::t_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.line_level = o_line_level;
            got.busy_res   = o_busy_res;
            got.frame_done = o_frame_done;
            got.bad_index  = o_bad_index;
            board.check_result(got);
            results_seen++;
        end
    end

    // Idle pattern follows progress: receiver-heavy, then sender-heavy, then none.
    task automatic send_item(input t_led_item it);
        if (items_sent < 560) begin
            send_idle_pct = 37;
            recv_idle_pct = 70;
        end else if (items_sent < 1120) begin
            send_idle_pct = 70;
            recv_idle_pct = 37;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= it.operation;
        i_led_index <= it.led_index;
        i_red       <= it.red;
        i_green     <= it.green;
        i_blue      <= it.blue;
        do @(posedge i_clk); while (o_in_stall);
        board.note_input(it);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_tick();
        t_led_item it;
        it = {rlcs_pkg::OP_TICK, rlcs_pkg::IDX_W'($urandom), 24'($urandom)};
        send_item(it);
    endtask

    task automatic send_write(input logic [rlcs_pkg::IDX_W-1:0] idx,
                              input logic [rlcs_pkg::CHAN_W-1:0] red,
                              input logic [rlcs_pkg::CHAN_W-1:0] green,
                              input logic [rlcs_pkg::CHAN_W-1:0] blue);
        send_item({rlcs_pkg::OP_WRITE, idx, red, green, blue});
    endtask

    function automatic logic [rlcs_pkg::CHAN_W-1:0] pick_channel();
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            default: return rlcs_pkg::CHAN_W'($urandom);
        endcase
    endfunction

    task automatic write_reg(input logic [rlcs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rlcs_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.note_config(idx, data);
        @(negedge i_clk);
    endtask

    // Drain the pipeline, let the block settle, then load a new timing set.
    task automatic reconfigure(input logic [rlcs_pkg::TICK_W-1:0] h_one,
                               input logic [rlcs_pkg::TICK_W-1:0] h_zero,
                               input logic [rlcs_pkg::TICK_W-1:0] period,
                               input logic [rlcs_pkg::GAP_W-1:0] latch);
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_GAP) @(negedge i_clk);
        write_reg(rlcs_pkg::CFG_HIGH_ONE, rlcs_pkg::CFG_DATA_W'(h_one));
        write_reg(rlcs_pkg::CFG_HIGH_ZERO, rlcs_pkg::CFG_DATA_W'(h_zero));
        write_reg(rlcs_pkg::CFG_BIT_TICKS, rlcs_pkg::CFG_DATA_W'(period));
        write_reg(rlcs_pkg::CFG_LATCH, latch);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly ticks with random noise on the unused fields, some writes, a few bad indexes.
    task automatic run_random(input int unsigned count, input int unsigned write_permille);
        t_led_item it;
        repeat (count) begin
            it.operation = ($urandom_range(999) < write_permille) ? rlcs_pkg::OP_WRITE
                                                                  : rlcs_pkg::OP_TICK;
            if ($urandom_range(9) == 0)
                it.led_index = rlcs_pkg::IDX_W'($urandom_range(7, LED_COUNT));
            else
                it.led_index = rlcs_pkg::IDX_W'($urandom_range(LED_COUNT - 1));
            it.red   = pick_channel();
            it.green = pick_channel();
            it.blue  = pick_channel();
            send_item(it);
        end
    endtask

    // Main sequence.
    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_operation = rlcs_pkg::OP_TICK;
        i_led_index = '0;
        i_red       = '0;
        i_green     = '0;
        i_blue      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = rlcs_pkg::CFG_HIGH_ONE;
        i_cfg_data  = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Shortest period with an oversized one-bit high time and a zero-bit high of zero.
        reconfigure(8'd255, 8'd0, 8'd2, 16'd0);

        // Directed items: bad indexes, idle start, writes while busy, extreme colors.
        send_tick();
        send_write(3'd7, 8'hFF, 8'hFF, 8'hFF);
        send_write(3'(LED_COUNT), 8'h12, 8'h34, 8'h56);
        send_write(3'd0, 8'hFF, 8'hFF, 8'hFF);
        repeat (3) send_tick();
        send_write(3'd2, 8'h00, 8'h00, 8'h00);
        send_write(3'd1, 8'h5A, 8'hA5, 8'h80);
        repeat (4) send_tick();
        send_write(3'd4, 8'h00, 8'h00, 8'h00);
        send_write(3'd0, 8'h01, 8'h80, 8'hFE);
        repeat (4) send_tick();
        run_random(180, 20);

        reconfigure(8'd2, 8'd1, 8'd3, 16'd7);
        run_random(200, 5);

        // Period below the minimum acts as two.
        reconfigure(8'd1, 8'd1, 8'd0, 16'd1);
        run_random(180, 25);

        reconfigure(8'd0, 8'd255, 8'd1, 16'd0);
        run_random(140, 5);

        reconfigure(8'd3, 8'd1, 8'd4, 16'd20);
        run_random(250, 15);

        // Longest period, changed while a frame may still be in flight.
        reconfigure(8'd254, 8'd1, 8'd255, 16'd3);
        run_random(350, 10);

        reconfigure(8'd4, 8'd2, 8'd6, 16'd0);
        run_random(200, 3);

        // Longest latch gap; the run ends inside it.
        reconfigure(8'd200, 8'd100, 8'd3, 16'hFFFF);
        run_random(150, 20);

        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
rtl/rlcs_pkg.sv
rtl/rlcs_cfg.sv
rtl/rlcs_engine.sv
rtl/rgb_led_chain_serializer_core.sv
rtl/rlcs_checker.sv
dv/rgb_led_chain_serializer_core_test.sv
